/* hdl/nsc_pkg.sv */
// Shared types, character codes and helpers for the sentence checker.
// No dependencies; used by nsc_line_state and nmea_sentence_checker_top.
package nsc_pkg;

    // Longest accepted line in bytes, newline included
    localparam logic [6:0] MAX_LINE = 7'd81;
    localparam logic [6:0] LEN_SAT  = 7'd127;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Sentence headers as they sit in the six-byte window
    localparam logic [47:0] HDR_GGA = 48'h244750474741;
    localparam logic [47:0] HDR_GSA = 48'h244750475341;
    localparam logic [47:0] HDR_RMC = 48'h244750524D43;
    localparam logic [47:0] HDR_GSV = 48'h244750475356;

    // Bit positions in the sticky header flags
    localparam int FLG_GGA = 0;
    localparam int FLG_GSA = 1;
    localparam int FLG_RMC = 2;
    localparam int FLG_GSV = 3;

    // One line report
    typedef struct packed {
        logic       checksum_ok;
        logic [7:0] computed_sum;
        logic [7:0] stated_sum;
        logic       found_gga;
        logic       found_gsa;
        logic       found_rmc;
        logic       found_gsv;
        logic       too_long;
    } t_result;

    // Hex digit decode: bit 4 set means not a hex digit, else bits 3:0 hold the value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = 5'h10;
        if (b inside {[8'h30:8'h39]}) begin
            d = {1'b0, 4'(b - 8'h30)};
        end else if (b inside {[8'h41:8'h46]}) begin
            d = {1'b0, 4'(b - 8'h37)};
        end else if (b inside {[8'h61:8'h66]}) begin
            d = {1'b0, 4'(b - 8'h57)};
        end
        return d;
    endfunction

endpackage

/* hdl/nmea_sentence_checker_top.sv */
// Top level of the sentence checker: input byte register, line state,
// result register. Depends on nsc_pkg and nsc_line_state.
//
// Usage:
//   Input channel: i_valid / o_ready carry one received byte on
//   i_byte_value per transaction. A newline (0x0A) ends a line.
//   Output channel: o_valid / i_ready carry one line report per newline:
//   checksum_ok, computed_sum, stated_sum, the four header flags and
//   too_long. Other bytes produce no report.
//   Throughput: one byte per cycle, sustained, as long as reports are taken.
//   Report path: an accepted newline sits in the input register, and when
//   it is consumed the line logic loads its report into the result
//   register, which offers it on o_valid.
//   Reset (synchronous, active low) empties both registers and clears the
//   line state, as if a line had just ended.
//   Receiver stall: the report waits in the result register; ordinary
//   bytes keep flowing, and a newline waits in the input register until
//   the result register is taken, with o_ready held low meanwhile.
module nmea_sentence_checker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_checksum_ok,
    output logic [7:0] o_computed_sum,
    output logic [7:0] o_stated_sum,
    output logic       o_found_gga,
    output logic       o_found_gsa,
    output logic       o_found_rmc,
    output logic       o_found_gsv,
    output logic       o_too_long
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    nsc_pkg::t_result r_out;
    nsc_pkg::t_result w_result;
    logic             w_is_nl;
    logic             w_consume;

    // Byte in the input register is consumed unless it needs a blocked result slot
    assign w_is_nl   = (r_in_byte == nsc_pkg::CH_NEWLINE);
    assign w_consume = r_in_valid && (!w_is_nl || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte_value;
        end
    end

    nsc_line_state u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_consume),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume && w_is_nl) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && w_is_nl) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_checksum_ok  = r_out.checksum_ok;
    assign o_computed_sum = r_out.computed_sum;
    assign o_stated_sum   = r_out.stated_sum;
    assign o_found_gga    = r_out.found_gga;
    assign o_found_gsa    = r_out.found_gsa;
    assign o_found_rmc    = r_out.found_rmc;
    assign o_found_gsv    = r_out.found_gsv;
    assign o_too_long     = r_out.too_long;

    // Header flags are only reported on a passing line
    a_flags_need_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.found_gga || r_out.found_gsa || r_out.found_rmc ||
                        r_out.found_gsv) |-> r_out.checksum_ok)
        else $error("header flag reported on failed line");

    // An over-long line never passes
    a_long_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.too_long |-> !r_out.checksum_ok)
        else $error("over-long line reported as passing");

    // A newline is never consumed while an untaken report would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && w_is_nl && r_out_valid |-> i_ready)
        else $error("result register overwritten before transfer");

endmodule

/* hdl/nsc_line_state.sv */
// Per-line state of the sentence checker: running XOR, stated hex sum,
// header window, sticky flags, length. Depends on nsc_pkg.
module nsc_line_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output nsc_pkg::t_result  o_result
);

    localparam logic [1:0] PH_BODY = 2'd0;
    localparam logic [1:0] PH_HEX  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0]  r_phase,  n_phase;
    logic [7:0]  r_xor,    n_xor;
    logic [7:0]  r_hex,    n_hex;
    logic        r_ovf,    n_ovf;
    logic [47:0] r_window, n_window;
    logic [3:0]  r_seen,   n_seen;
    logic [6:0]  r_len,    n_len;
    logic        r_bad,    n_bad;

    logic        w_newline;
    logic        w_long;
    logic        w_ok;
    logic [4:0]  w_digit;

    assign w_newline = (i_byte == nsc_pkg::CH_NEWLINE);
    assign w_digit   = nsc_pkg::hex_digit(i_byte);

    // Line report, meaningful when the byte is a newline
    always_comb begin
        w_long = (r_len >= nsc_pkg::MAX_LINE);
        w_ok   = (r_phase != PH_BODY) && !r_bad && !r_ovf && !w_long && (r_hex == r_xor);
        o_result.checksum_ok  = w_ok;
        o_result.computed_sum = r_xor;
        o_result.stated_sum   = r_hex;
        o_result.found_gga    = w_ok && r_seen[nsc_pkg::FLG_GGA];
        o_result.found_gsa    = w_ok && r_seen[nsc_pkg::FLG_GSA];
        o_result.found_rmc    = w_ok && r_seen[nsc_pkg::FLG_RMC];
        o_result.found_gsv    = w_ok && r_seen[nsc_pkg::FLG_GSV];
        o_result.too_long     = w_long;
    end

    // Next line state for one byte
    always_comb begin
        n_phase  = r_phase;
        n_xor    = r_xor;
        n_hex    = r_hex;
        n_ovf    = r_ovf;
        n_window = r_window;
        n_seen   = r_seen;
        n_len    = r_len;
        n_bad    = r_bad;
        if (w_newline) begin
            // newline closes the line: start clean
            n_phase  = PH_BODY;
            n_xor    = '0;
            n_hex    = '0;
            n_ovf    = 1'b0;
            n_window = '0;
            n_seen   = '0;
            n_len    = '0;
            n_bad    = 1'b0;
        end else begin
            if (r_len != nsc_pkg::LEN_SAT) begin
                n_len = r_len + 7'd1;
            end
            if (i_byte == nsc_pkg::CH_NUL) begin
                n_bad = 1'b1;
            end
            // header detect on the shifted window
            n_window = {r_window[39:0], i_byte};
            if (n_window == nsc_pkg::HDR_GGA) n_seen[nsc_pkg::FLG_GGA] = 1'b1;
            if (n_window == nsc_pkg::HDR_GSA) n_seen[nsc_pkg::FLG_GSA] = 1'b1;
            if (n_window == nsc_pkg::HDR_RMC) n_seen[nsc_pkg::FLG_RMC] = 1'b1;
            if (n_window == nsc_pkg::HDR_GSV) n_seen[nsc_pkg::FLG_GSV] = 1'b1;
            // checksum body, then stated hex digits
            case (r_phase)
                PH_BODY: begin
                    if (i_byte == nsc_pkg::CH_STAR) begin
                        n_phase = PH_HEX;
                    end else if (i_byte != nsc_pkg::CH_DOLLAR) begin
                        n_xor = r_xor ^ i_byte;
                    end
                end
                PH_HEX: begin
                    if (!w_digit[4]) begin
                        if (r_hex[7:4] != 4'd0) n_ovf = 1'b1;
                        n_hex = {r_hex[3:0], w_digit[3:0]};
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BODY;
            r_xor    <= '0;
            r_hex    <= '0;
            r_ovf    <= 1'b0;
            r_window <= '0;
            r_seen   <= '0;
            r_len    <= '0;
            r_bad    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_xor    <= n_xor;
            r_hex    <= n_hex;
            r_ovf    <= n_ovf;
            r_window <= n_window;
            r_seen   <= n_seen;
            r_len    <= n_len;
            r_bad    <= n_bad;
        end
    end

    // A consumed newline leaves a fresh line behind
    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_newline |=> (r_len == 7'd0) && (r_phase == PH_BODY) && (r_seen == 4'd0))
        else $error("line state not cleared after newline");

    // Stated sum only collects digits after the star
    a_hex_needs_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hex != 8'd0) |-> (r_phase != PH_BODY))
        else $error("hex value set while still in body");

    // Overflow only arises once digits are being read
    a_ovf_needs_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_phase != PH_BODY))
        else $error("hex overflow set while still in body");

endmodule
